[sv/pat_pkg.sv]
package pat_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN = 24;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032875;
  localparam logic [0:0] REG_LINK_LENGTH = 1'b0;
  localparam logic [0:0] REG_BASE_HEIGHT = 1'b1;

  typedef logic signed [CW-1:0] cval_t;

  function automatic cval_t arctan_turn(input int i);
    cval_t t;
    case (i)
      0: t = 34'sd536870912;
      1: t = 34'sd316933406;
      2: t = 34'sd167458907;
      3: t = 34'sd85004756;
      4: t = 34'sd42667331;
      5: t = 34'sd21354465;
      6: t = 34'sd10679838;
      7: t = 34'sd5340245;
      8: t = 34'sd2670163;
      9: t = 34'sd1335087;
      10: t = 34'sd667544;
      11: t = 34'sd333772;
      12: t = 34'sd166886;
      13: t = 34'sd83443;
      14: t = 34'sd41722;
      15: t = 34'sd20861;
      16: t = 34'sd10430;
      17: t = 34'sd5215;
      18: t = 34'sd2608;
      19: t = 34'sd1304;
      20: t = 34'sd652;
      21: t = 34'sd326;
      22: t = 34'sd163;
      23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[sv/planar_arm_tip_pose.sv]
// Tip pose of a planar three-link arm: one pose beat in, one tip beat out,
// fully pipelined at one beat per clock while out_stall is low. NS is
// CORDIC_STAGES capped at 24. Stages: one stage for angle sums and quadrant
// fold, one per cordic iteration (three rotators side by side), then link sum,
// partial products, product combine, and round/saturate.
// A stall on the output freezes the whole pipeline in place; in_stall simply
// mirrors out_stall, so nothing is lost or repeated. Configuration registers
// (link_length, base_height) must only be written while the pipe is empty.
module planar_arm_tip_pose #(
  parameter int CORDIC_STAGES = pat_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_base_x,
  input  logic signed [23:0] in_base_y,
  input  logic signed [15:0] in_joint_angle_1,
  input  logic signed [15:0] in_joint_angle_2,
  input  logic signed [15:0] in_joint_angle_3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_tip_x,
  output logic signed [23:0] out_tip_y,
  output logic signed [15:0] out_tip_direction,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // iterations actually run, table holds 24
  localparam int NS = (CORDIC_STAGES > pat_pkg::TABLE_LEN) ? pat_pkg::TABLE_LEN
                                                           : CORDIC_STAGES;
  localparam int NP = NS + 5;

  logic [15:0] link_length_r, base_height_r;
  logic        adv;

  assign adv = !out_stall;
  assign in_stall = out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_length_r <= '0;
      base_height_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pat_pkg::REG_LINK_LENGTH: link_length_r <= cfg_data;
        pat_pkg::REG_BASE_HEIGHT: base_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits for every stage
  logic [NP-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NP-2:0], in_valid};
  end

  // base position and direction ride along with the cordic stages
  logic signed [23:0] bx_r [NS+2];
  logic signed [23:0] by_r [NS+2];
  logic signed [15:0] dir_r [NS+2];

  // cordic state: stage 0 is the fold result
  pat_pkg::cval_t x_r [NS+1][3];
  pat_pkg::cval_t y_r [NS+1][3];
  pat_pkg::cval_t z_r [NS+1][3];
  logic [2:0]     flip_r [NS+1];

  // stage 0: angle sums, fold into +-quarter turn
  logic signed [15:0] ang [3];
  always_comb begin
    ang[0] = in_joint_angle_1;
    ang[1] = in_joint_angle_1 + in_joint_angle_2;
    ang[2] = in_joint_angle_1 + in_joint_angle_2 + in_joint_angle_3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bx_r[0]  <= in_base_x;
      by_r[0]  <= in_base_y;
      dir_r[0] <= ang[2] + 16'sd16384;
      for (int k = 0; k < 3; k++) begin
        x_r[0][k] <= pat_pkg::GAIN_Q30;
        y_r[0][k] <= '0;
        // z = ang * 65536, fold when beyond a quarter turn
        if (ang[k] > 16'sd16384) begin
          z_r[0][k]     <= pat_pkg::cval_t'($signed({ang[k], 16'd0})) - (34'sd1 <<< 31);
          flip_r[0][k]  <= 1'b1;
        end else if (ang[k] < -16'sd16384) begin
          z_r[0][k]     <= pat_pkg::cval_t'($signed({ang[k], 16'd0})) + (34'sd1 <<< 31);
          flip_r[0][k]  <= 1'b1;
        end else begin
          z_r[0][k]     <= pat_pkg::cval_t'($signed({ang[k], 16'd0}));
          flip_r[0][k]  <= 1'b0;
        end
      end
    end
  end

  // cordic iterations
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        bx_r[i+1]   <= bx_r[i];
        by_r[i+1]   <= by_r[i];
        dir_r[i+1]  <= dir_r[i];
        flip_r[i+1] <= flip_r[i];
        for (int k = 0; k < 3; k++) begin
          if (!z_r[i][k][pat_pkg::CW-1]) begin
            x_r[i+1][k] <= x_r[i][k] - (y_r[i][k] >>> i);
            y_r[i+1][k] <= y_r[i][k] + (x_r[i][k] >>> i);
            z_r[i+1][k] <= z_r[i][k] - pat_pkg::arctan_turn(i);
          end else begin
            x_r[i+1][k] <= x_r[i][k] + (y_r[i][k] >>> i);
            y_r[i+1][k] <= y_r[i][k] - (x_r[i][k] >>> i);
            z_r[i+1][k] <= z_r[i][k] + pat_pkg::arctan_turn(i);
          end
        end
      end
    end
  end

  // sum the three links (sign-corrected)
  logic signed [33:0] cs_r, ss_r;
  pat_pkg::cval_t cf [3];
  pat_pkg::cval_t sf [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cf[k] = flip_r[NS][k] ? -x_r[NS][k] : x_r[NS][k];
      sf[k] = flip_r[NS][k] ? -y_r[NS][k] : y_r[NS][k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r <= cf[0] + cf[1] + cf[2];
      ss_r <= sf[0] + sf[1] + sf[2];
      bx_r[NS+1]  <= bx_r[NS];
      by_r[NS+1]  <= by_r[NS];
      dir_r[NS+1] <= dir_r[NS];
    end
  end

  // multiply by L in two halves: low 17 bits and high 17 bits of each sum
  logic signed [34:0] clo_r, slo_r, chi_r, shi_r;
  logic signed [16:0] len_s;
  logic signed [23:0] bx2_r, by2_r, bx3_r, by3_r;
  logic signed [15:0] dir2_r, dir3_r;
  logic               lz2_r, lz3_r;
  assign len_s = {1'b0, link_length_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      clo_r  <= $signed({1'b0, cs_r[16:0]}) * len_s;
      slo_r  <= $signed({1'b0, ss_r[16:0]}) * len_s;
      chi_r  <= $signed(cs_r[33:17]) * len_s;
      shi_r  <= $signed(ss_r[33:17]) * len_s;
      bx2_r  <= bx_r[NS+1];
      by2_r  <= by_r[NS+1];
      dir2_r <= dir_r[NS+1];
      lz2_r  <= (link_length_r == 16'd0);
    end
  end

  logic signed [51:0] cp_r, sp_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cp_r   <= (52'(chi_r) <<< 17) + 52'(clo_r);
      sp_r   <= (52'(shi_r) <<< 17) + 52'(slo_r);
      bx3_r  <= bx2_r;
      by3_r  <= by2_r;
      dir3_r <= dir2_r;
      lz3_r  <= lz2_r;
    end
  end

  // round off the Q30 fraction, add base, saturate
  logic signed [52:0] tx, ty;
  logic signed [23:0] tx_sat, ty_sat;
  always_comb begin
    tx = 53'(bx3_r) + ((-53'(sp_r) + (53'sd1 <<< 29)) >>> 30);
    ty = 53'(by3_r) + 53'($signed({1'b0, base_height_r}))
       + ((53'(cp_r) + (53'sd1 <<< 29)) >>> 30);
    if (tx > 53'sd8388607)       tx_sat = 24'sh7fffff;
    else if (tx < -53'sd8388608) tx_sat = 24'sh800000;
    else                         tx_sat = tx[23:0];
    if (ty > 53'sd8388607)       ty_sat = 24'sh7fffff;
    else if (ty < -53'sd8388608) ty_sat = 24'sh800000;
    else                         ty_sat = ty[23:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tip_x         <= tx_sat;
      out_tip_y         <= ty_sat;
      out_tip_direction <= lz3_r ? 16'sd0 : dir3_r;
    end
  end

  assign out_valid = vld_r[NP-1];

endmodule

[bench/tb_planar_arm_tip_pose.sv]
`timescale 1ns / 100ps

module tb_planar_arm_tip_pose;

  localparam int STAGES = pat_pkg::CORDIC_STAGES_DEF;
  // pipeline depth from the block header, plus margin
  localparam int PIPE_LAT = STAGES + 6;

  typedef struct {
    logic signed [23:0] tip_x;
    logic signed [23:0] tip_y;
    logic signed [15:0] tip_dir;
  } tip_pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_base_x = '0;
  logic signed [23:0] in_base_y = '0;
  logic signed [15:0] in_joint_angle_1 = '0;
  logic signed [15:0] in_joint_angle_2 = '0;
  logic signed [15:0] in_joint_angle_3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_tip_x;
  logic signed [23:0] out_tip_y;
  logic signed [15:0] out_tip_direction;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  planar_arm_tip_pose dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the two registers
  longint link_len;
  longint shoulder_h;

  tip_pose_t pose_q[$];
  int mismatches;
  int busy_hold;      // receiver long hold-off, in cycles
  bit hold_req;

  int arctan_tab[pat_pkg::TABLE_LEN] = '{536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_turn(longint v);
    logic signed [15:0] w;
    w = v[15:0];
    return longint'(w);
  endfunction

  // rotation-mode cordic, q30 cosine and sine of a binary angle
  task automatic rotate_unit(input longint ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    int n;
    z = ang * 65536;
    x = 652032875;
    y = 0;
    flip = 0;
    n = (STAGES > pat_pkg::TABLE_LEN) ? pat_pkg::TABLE_LEN : STAGES;
    if (z > (64'sd1 << 30)) begin
      z -= 64'sd1 << 31;
      flip = 1;
    end else if (z < -(64'sd1 << 30)) begin
      z += 64'sd1 << 31;
      flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - fl_shr(y, i);
        y = y + fl_shr(x, i);
        z -= arctan_tab[i];
      end else begin
        nx = x + fl_shr(y, i);
        y = y - fl_shr(x, i);
        z += arctan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint clamp_pos(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic predict_tip(input longint bx, by, a1, a2, a3);
    longint ang[3];
    longint csum, ssum, c, s, tx, ty, dir;
    tip_pose_t p;
    csum = 0;
    ssum = 0;
    ang[0] = wrap_turn(a1);
    ang[1] = wrap_turn(a1 + a2);
    ang[2] = wrap_turn(a1 + a2 + a3);
    for (int k = 0; k < 3; k++) begin
      rotate_unit(ang[k], c, s);
      csum += c;
      ssum += s;
    end
    tx = bx + fl_shr(-link_len * ssum + (64'sd1 << 29), 30);
    ty = by + shoulder_h + fl_shr(link_len * csum + (64'sd1 << 29), 30);
    dir = (link_len == 0) ? 0 : wrap_turn(ang[2] + 16384);
    p.tip_x = 24'(clamp_pos(tx));
    p.tip_y = 24'(clamp_pos(ty));
    p.tip_dir = 16'(dir);
    pose_q.push_back(p);
  endtask

  // one beat on the pose channel; valid stays up across back-to-back beats
  task automatic send_pose(input logic signed [23:0] bx, by,
                           input logic signed [15:0] a1, a2, a3, input bit keep);
    in_valid <= 1'b1;
    in_base_x <= bx;
    in_base_y <= by;
    in_joint_angle_1 <= a1;
    in_joint_angle_2 <= a2;
    in_joint_angle_3 <= a3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tip(bx, by, a1, a2, a3);
    if (!keep) in_valid <= 1'b0;
  endtask

  task automatic send_rand(input int cnt);
    int burst;
    bit gap;
    bit last_keep;
    while (cnt > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > cnt) burst = cnt;
      gap = ($urandom_range(0, 3) != 0);
      // valid stays up into the next burst when there is no gap
      last_keep = !gap && (cnt > burst);
      for (int i = 0; i < burst; i++)
        send_pose(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), (i < burst - 1) || last_keep);
      cnt -= burst;
      if (gap) repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_pipe;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // register write; only called with the pipe empty
  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val, input bit keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!keep) cfg_valid <= 1'b0;
    if (idx == pat_pkg::REG_LINK_LENGTH) link_len = val;
    else shoulder_h = val;
  endtask

  task automatic set_arm(input logic [15:0] len, input logic [15:0] h);
    drain_pipe();
    write_reg(pat_pkg::REG_LINK_LENGTH, len, 1'b1);
    write_reg(pat_pkg::REG_BASE_HEIGHT, h, 1'b0);
  endtask

  // field extremes, quadrant folds, angle wrap and zero length
  task automatic test_directed;
    logic signed [15:0] angs[8] = '{16'sh0000, 16'sh4000, 16'shC000, 16'sh7FFF,
      16'sh8000, 16'sh4001, 16'shBFFF, 16'sh0001};
    set_arm(16'd0, 16'd0);
    send_pose(24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    send_pose(24'sh000000, 24'sh7FFFFF, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    set_arm(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++)
      send_pose(24'sh0, 24'sh0, angs[i], angs[7 - i], angs[(i + 3) % 8], 1);
    // saturation at both ends
    send_pose(24'sh7FFFFF, 24'sh7FFFFF, 16'shC000, 16'sh0, 16'sh0, 1);
    send_pose(24'sh800000, 24'sh800000, 16'sh4000, 16'sh0, 16'sh0, 1);
    send_pose(24'sh7FFFF0, 24'sh800010, 16'sh8000, 16'sh0, 16'sh0, 0);
    set_arm(16'h0100, 16'h0000);
    for (int i = 0; i < 6; i++)
      send_pose(24'($urandom), 24'($urandom), angs[i], angs[i + 1], angs[i + 2], i < 5);
  endtask

  task automatic test_random_arms;
    set_arm(16'($urandom_range(0, 16'h0400)), 16'($urandom));
    send_rand(400);
    set_arm(16'hFFFF, 16'hFFFF);
    send_rand(300);
    set_arm(16'($urandom), 16'($urandom));
    send_rand(400);
    set_arm(16'h0000, 16'($urandom));
    send_rand(150);
  endtask

  // long receiver hold-off while poses keep coming, then a full drain pause
  task automatic test_backpressure;
    set_arm(16'($urandom), 16'($urandom));
    hold_req = 1;
    send_rand(200);
    hold_req = 0;
    drain_pipe();
    send_rand(50);
  endtask

  // receiver stall pattern: runs of free and stalled cycles, plus hold-off
  initial begin
    int run;
    forever begin
      if (hold_req) begin
        busy_hold = 0;
        out_stall <= 1'b1;
        while (busy_hold < 3 * PIPE_LAT + 40) begin
          @(posedge clk);
          busy_hold++;
        end
        hold_req = 0;
      end
      run = $urandom_range(1, 12);
      out_stall <= ($urandom_range(0, 2) == 0);
      repeat (run) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    tip_pose_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tip beat at %0t", $time);
      end else begin
        e = pose_q.pop_front();
        if (out_tip_x !== e.tip_x || out_tip_y !== e.tip_y ||
            out_tip_direction !== e.tip_dir) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tip mismatch: exp x=%0d y=%0d dir=%0d got x=%0d y=%0d dir=%0d",
                     e.tip_x, e.tip_y, e.tip_dir, out_tip_x, out_tip_y,
                     out_tip_direction);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    link_len = 0;
    shoulder_h = 0;
    hold_req = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_arms();
    test_backpressure();
    drain_pipe();
    if (mismatches == 0 && pose_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
sv/pat_pkg.sv
sv/planar_arm_tip_pose.sv
bench/tb_planar_arm_tip_pose.sv
